/* rtl/dsu_pkg.sv */
package dsu_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int IDX_W        = 10;
    localparam int RANK_W       = 4;
    localparam int CNT_W        = 11;
    localparam int STEP_W       = 11;
    localparam int WORD_W       = RANK_W + IDX_W;
    localparam int UPC_W        = 4;

    localparam logic [RANK_W-1:0] RANK_MAX  = 4'd15;
    localparam logic [CNT_W-1:0]  COUNT_RST = 11'd1024;
    localparam logic [STEP_W-1:0] WALK_MAX  = STEP_W'(MAX_ELEMENTS);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(MAX_ELEMENTS - 1);

    // datapath operation of one step
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_READ,
        OP_WALK,
        OP_COMPRESS,
        OP_SAVE_A,
        OP_LINK,
        OP_BUMP,
        OP_EMIT,
        OP_CLEAR
    } op_t;

    // jump condition of one step
    typedef enum logic [3:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NO_ITEM,
        JC_ERR,
        JC_FIND,
        JC_NOT_ROOT,
        JC_COMP_DONE,
        JC_SWEEP_MORE,
        JC_OUT_BUSY
    } jc_t;

    typedef struct packed {
        op_t              op;
        jc_t              jc;
        logic [UPC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic no_item;
        logic err;
        logic find;
        logic not_root;
        logic comp_done;
        logic sweep_more;
        logic out_busy;
    } flags_t;

    // program addresses
    localparam logic [UPC_W-1:0] UA_IDLE  = 4'd0;
    localparam logic [UPC_W-1:0] UA_CHECK = 4'd1;
    localparam logic [UPC_W-1:0] UA_A_RD  = 4'd2;
    localparam logic [UPC_W-1:0] UA_A_WLK = 4'd3;
    localparam logic [UPC_W-1:0] UA_A_CRD = 4'd4;
    localparam logic [UPC_W-1:0] UA_A_CMP = 4'd5;
    localparam logic [UPC_W-1:0] UA_SAVE  = 4'd6;
    localparam logic [UPC_W-1:0] UA_B_RD  = 4'd7;
    localparam logic [UPC_W-1:0] UA_B_WLK = 4'd8;
    localparam logic [UPC_W-1:0] UA_B_CRD = 4'd9;
    localparam logic [UPC_W-1:0] UA_B_CMP = 4'd10;
    localparam logic [UPC_W-1:0] UA_LINK  = 4'd11;
    localparam logic [UPC_W-1:0] UA_BUMP  = 4'd12;
    localparam logic [UPC_W-1:0] UA_CLEAR = 4'd13;
    localparam logic [UPC_W-1:0] UA_REST  = 4'd14;
    localparam logic [UPC_W-1:0] UA_EMIT  = 4'd15;

    // control store; emit is the last word so falling through wraps to idle
    function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
        uword_t w;
        unique case (addr)
            UA_IDLE:  w = '{OP_ACCEPT,   JC_NO_ITEM,    UA_IDLE};
            UA_CHECK: w = '{OP_NOP,      JC_ERR,        UA_EMIT};
            UA_A_RD:  w = '{OP_READ,     JC_NEVER,      UA_IDLE};
            UA_A_WLK: w = '{OP_WALK,     JC_NOT_ROOT,   UA_A_WLK};
            UA_A_CRD: w = '{OP_READ,     JC_COMP_DONE,  UA_SAVE};
            UA_A_CMP: w = '{OP_COMPRESS, JC_ALWAYS,     UA_A_CRD};
            UA_SAVE:  w = '{OP_SAVE_A,   JC_FIND,       UA_EMIT};
            UA_B_RD:  w = '{OP_READ,     JC_NEVER,      UA_IDLE};
            UA_B_WLK: w = '{OP_WALK,     JC_NOT_ROOT,   UA_B_WLK};
            UA_B_CRD: w = '{OP_READ,     JC_COMP_DONE,  UA_LINK};
            UA_B_CMP: w = '{OP_COMPRESS, JC_ALWAYS,     UA_B_CRD};
            UA_LINK:  w = '{OP_LINK,     JC_NEVER,      UA_IDLE};
            UA_BUMP:  w = '{OP_BUMP,     JC_ALWAYS,     UA_EMIT};
            UA_CLEAR: w = '{OP_CLEAR,    JC_SWEEP_MORE, UA_CLEAR};
            UA_REST:  w = '{OP_NOP,      JC_ALWAYS,     UA_IDLE};
            UA_EMIT:  w = '{OP_EMIT,     JC_OUT_BUSY,   UA_EMIT};
            default:  w = '{OP_NOP,      JC_ALWAYS,     UA_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* rtl/dsu_ram.sv */
module dsu_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/dsu_seq.sv */
module dsu_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            restart,
    input  dsu_pkg::flags_t flags,
    output dsu_pkg::uword_t word
);

    logic [dsu_pkg::UPC_W-1:0] upc_reg;
    logic [dsu_pkg::UPC_W-1:0] upc_next;
    dsu_pkg::uword_t           cur;
    logic                      taken;

    assign cur = dsu_pkg::ucode(upc_reg);

    always_comb
    begin
        unique case (cur.jc)
            dsu_pkg::JC_NEVER:      taken = 1'b0;
            dsu_pkg::JC_ALWAYS:     taken = 1'b1;
            dsu_pkg::JC_NO_ITEM:    taken = flags.no_item;
            dsu_pkg::JC_ERR:        taken = flags.err;
            dsu_pkg::JC_FIND:       taken = flags.find;
            dsu_pkg::JC_NOT_ROOT:   taken = flags.not_root;
            dsu_pkg::JC_COMP_DONE:  taken = flags.comp_done;
            dsu_pkg::JC_SWEEP_MORE: taken = flags.sweep_more;
            dsu_pkg::JC_OUT_BUSY:   taken = flags.out_busy;
            default:                taken = 1'b0;
        endcase
    end

    always_comb
    begin
        priority if (restart)
        begin
            upc_next = dsu_pkg::UA_CLEAR;
        end
        else if (taken)
        begin
            upc_next = cur.target;
        end
        else
        begin
            upc_next = upc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= dsu_pkg::UA_CLEAR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign word = cur;

endmodule

/* rtl/disjoint_set_union_find.sv */
// disjoint-set table over 1024 elements, union by rank with path compression
//
// input channel (in_valid / in_stall): action, first_index, second_index.
// action 0 finds the root of first_index, action 1 unions both elements.
// output channel (out_valid / out_stall): first_root, second_root, joined,
// status. one result beat per input beat, in order.
//
// a small microcode program steps a single-port-read table of parent links
// and ranks; a walk follows one link per step, and compression rewrites
// each link in a read step and a write step. an index out of range goes
// straight from the check step to the result. a new beat is taken in the
// cycle after the result enters the output register, so no new beat is
// taken before the last one is through.
//
// reset and every write of element_count (cfg_write_en / cfg_write_data)
// start a clearing pass that sets each element as its own root with rank
// zero; in_stall stays high meanwhile.
// when out_stall holds the result, the sequencer waits on its emit step.
module disjoint_set_union_find (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [10:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [9:0]  first_index,
    input  logic [9:0]  second_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [9:0]  first_root,
    output logic [9:0]  second_root,
    output logic        joined,
    output logic        status
);

    localparam int IW = dsu_pkg::IDX_W;
    localparam int RW = dsu_pkg::RANK_W;
    localparam int WW = dsu_pkg::WORD_W;
    localparam int SW = dsu_pkg::STEP_W;

    dsu_pkg::uword_t word;
    dsu_pkg::flags_t flags;

    // control state
    logic [dsu_pkg::CNT_W-1:0] count_reg;
    logic [IW-1:0]             sweep_reg, sweep_next;
    logic                      out_valid_reg, out_valid_next;

    // datapath
    logic          action_reg, action_next;
    logic          err_reg, err_next;
    logic          bump_reg, bump_next;
    logic          joined_reg, joined_next;
    logic [IW-1:0] b_reg, b_next;
    logic [IW-1:0] node_reg, node_next;
    logic [IW-1:0] start_reg, start_next;
    logic [IW-1:0] root_reg, root_next;
    logic [RW-1:0] rank_reg, rank_next;
    logic [IW-1:0] ra_reg, ra_next;
    logic [RW-1:0] rka_reg, rka_next;
    logic [SW-1:0] steps_reg, steps_next;

    logic [IW-1:0] first_root_reg, first_root_next;
    logic [IW-1:0] second_root_reg, second_root_next;
    logic          joined_out_reg, joined_out_next;
    logic          status_reg, status_next;

    // table port
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [WW-1:0] wr_data;
    logic [IW-1:0] rd_addr;
    logic [WW-1:0] rd_data;
    logic [IW-1:0] rd_parent;
    logic [RW-1:0] rd_rank;

    logic walk_done;
    logic out_busy;
    logic in_err;

    assign rd_parent = rd_data[IW-1:0];
    assign rd_rank   = rd_data[WW-1:IW];

    assign walk_done = (rd_parent == node_reg) || (steps_reg == dsu_pkg::WALK_MAX);
    assign out_busy  = out_valid_reg && out_stall;

    // indices are below the table size, so comparing with the raw count suffices
    assign in_err = ({1'b0, first_index} >= count_reg)
                 || (action && ({1'b0, second_index} >= count_reg));

    assign flags = '{
        no_item:    !in_valid,
        err:        err_reg,
        find:       !action_reg,
        not_root:   !walk_done,
        comp_done:  (node_reg == root_reg) || (steps_reg == dsu_pkg::WALK_MAX),
        sweep_more: sweep_reg != dsu_pkg::LAST_IDX,
        out_busy:   out_busy
    };

    dsu_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_write_en),
        .flags   (flags),
        .word    (word)
    );

    dsu_ram #(
        .WIDTH (WW),
        .DEPTH (dsu_pkg::MAX_ELEMENTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        action_next      = action_reg;
        err_next         = err_reg;
        bump_next        = bump_reg;
        joined_next      = joined_reg;
        b_next           = b_reg;
        node_next        = node_reg;
        start_next       = start_reg;
        root_next        = root_reg;
        rank_next        = rank_reg;
        ra_next          = ra_reg;
        rka_next         = rka_reg;
        steps_next       = steps_reg;
        sweep_next       = sweep_reg;
        first_root_next  = first_root_reg;
        second_root_next = second_root_reg;
        joined_out_next  = joined_out_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg && out_stall;
        wr_en            = 1'b0;
        wr_addr          = node_reg;
        wr_data          = {rd_rank, root_reg};
        rd_addr          = node_reg;

        unique case (word.op)
            dsu_pkg::OP_NOP:
            begin
            end
            dsu_pkg::OP_ACCEPT:
            begin
                action_next = action;
                err_next    = in_err;
                b_next      = second_index;
                node_next   = first_index;
                start_next  = first_index;
                steps_next  = '0;
                bump_next   = 1'b0;
                joined_next = 1'b0;
            end
            dsu_pkg::OP_READ:
            begin
                rd_addr = node_reg;
            end
            dsu_pkg::OP_WALK:
            begin
                if (walk_done)
                begin
                    root_next  = node_reg;
                    rank_next  = rd_rank;
                    node_next  = start_reg;
                    steps_next = '0;
                end
                else
                begin
                    // chase the link straight away, one link a cycle
                    rd_addr    = rd_parent;
                    node_next  = rd_parent;
                    steps_next = steps_reg + 1'b1;
                end
            end
            dsu_pkg::OP_COMPRESS:
            begin
                wr_en      = 1'b1;
                wr_addr    = node_reg;
                wr_data    = {rd_rank, root_reg};
                node_next  = rd_parent;
                steps_next = steps_reg + 1'b1;
            end
            dsu_pkg::OP_SAVE_A:
            begin
                ra_next    = root_reg;
                rka_next   = rank_reg;
                node_next  = b_reg;
                start_next = b_reg;
                steps_next = '0;
            end
            dsu_pkg::OP_LINK:
            begin
                if (root_reg != ra_reg)
                begin
                    joined_next = 1'b1;
                    wr_en       = 1'b1;
                    if (rank_reg > rka_reg)
                    begin
                        wr_addr = ra_reg;
                        wr_data = {rka_reg, root_reg};
                    end
                    else
                    begin
                        // second root goes under the first, equal rank bumps it next step
                        wr_addr   = root_reg;
                        wr_data   = {rank_reg, ra_reg};
                        bump_next = (rank_reg == rka_reg);
                    end
                end
            end
            dsu_pkg::OP_BUMP:
            begin
                wr_en   = bump_reg;
                wr_addr = ra_reg;
                wr_data = {(rka_reg == dsu_pkg::RANK_MAX) ? rka_reg : rka_reg + 1'b1, ra_reg};
            end
            dsu_pkg::OP_EMIT:
            begin
                if (!out_busy)
                begin
                    out_valid_next   = 1'b1;
                    first_root_next  = err_reg ? '0 : ra_reg;
                    second_root_next = (err_reg || !action_reg) ? '0 : root_reg;
                    joined_out_next  = joined_reg;
                    status_next      = err_reg;
                end
            end
            dsu_pkg::OP_CLEAR:
            begin
                wr_en      = 1'b1;
                wr_addr    = sweep_reg;
                wr_data    = {{RW{1'b0}}, sweep_reg};
                sweep_next = sweep_reg + 1'b1;
            end
            default:
            begin
            end
        endcase

        if (cfg_write_en)
        begin
            sweep_next = '0;
        end
    end

    // the find path leaves through save, which loads ra before the emit step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= dsu_pkg::COUNT_RST;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                count_reg <= cfg_write_data;
            end
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg      <= action_next;
        err_reg         <= err_next;
        bump_reg        <= bump_next;
        joined_reg      <= joined_next;
        b_reg           <= b_next;
        node_reg        <= node_next;
        start_reg       <= start_next;
        root_reg        <= root_next;
        rank_reg        <= rank_next;
        ra_reg          <= ra_next;
        rka_reg         <= rka_next;
        steps_reg       <= steps_next;
        first_root_reg  <= first_root_next;
        second_root_reg <= second_root_next;
        joined_out_reg  <= joined_out_next;
        status_reg      <= status_next;
    end

    assign in_stall    = (word.op != dsu_pkg::OP_ACCEPT);
    assign out_valid   = out_valid_reg;
    assign first_root  = first_root_reg;
    assign second_root = second_root_reg;
    assign joined      = joined_out_reg;
    assign status      = status_reg;

endmodule
